// ===== sv/segment_intersection_classify_assert.svh =====
// Assertion macros for the segment intersection block.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SEGMENT_INTERSECTION_CLASSIFY_ASSERT_SVH
`define SEGMENT_INTERSECTION_CLASSIFY_ASSERT_SVH

// same-cycle implication
`define SIC_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SIC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/sic_pkg.sv =====
// Shared constants and types for the segment intersection block.
// No dependencies.
`timescale 1ns / 1ps

package sic_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int STATUS_W       = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE     = 3'd0,
        ST_HIT      = 3'd1,
        ST_PARALLEL = 3'd2,
        ST_DISJOINT = 3'd3,
        ST_TOUCH    = 3'd4,
        ST_OVERLAP  = 3'd5
    } status_t;

endpackage

// ===== sv/sic_stream_if.sv =====
// Valid/ready channels: segment pair in, classification result out.
// Depends on sic_pkg.
`timescale 1ns / 1ps

interface sic_seg_if #(
    parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] dx;
    logic signed [COORD_BITS-1:0] dy;

    modport source (output valid, ax, ay, bx, by, cx, cy, dx, dy, input ready);
    modport sink (input valid, ax, ay, bx, by, cx, cy, dx, dy, output ready);
endinterface

interface sic_res_if #(
    parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sic_pkg::FRAC_BITS_DEF
) ();
    logic                             valid;
    logic                             ready;
    logic [sic_pkg::STATUS_W-1:0]     status;
    logic signed [COORD_BITS-1:0]     hit_x;
    logic signed [COORD_BITS-1:0]     hit_y;
    logic [FRAC_BITS:0]               u_fraction;

    modport source (output valid, status, hit_x, hit_y, u_fraction, input ready);
    modport sink (input valid, status, hit_x, hit_y, u_fraction, output ready);
endinterface

// ===== sv/sic_front.sv =====
// Front stages: differences, cross products, sign fold, range tests.
// Five register stages. Depends on sic_pkg.
`timescale 1ns / 1ps

module sic_front #(
    parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic [4:0]                    en,
    input  logic signed [COORD_BITS-1:0]  ax,
    input  logic signed [COORD_BITS-1:0]  ay,
    input  logic signed [COORD_BITS-1:0]  bx,
    input  logic signed [COORD_BITS-1:0]  by,
    input  logic signed [COORD_BITS-1:0]  cx,
    input  logic signed [COORD_BITS-1:0]  cy,
    input  logic signed [COORD_BITS-1:0]  dx,
    input  logic signed [COORD_BITS-1:0]  dy,
    output sic_pkg::status_t              status,
    output logic                          hit,
    output logic [2*COORD_BITS+1:0]       t1,
    output logic [2*COORD_BITS+1:0]       den,
    output logic [COORD_BITS:0]           sx,
    output logic [COORD_BITS:0]           sy,
    output logic                          negx,
    output logic                          negy,
    output logic [COORD_BITS-1:0]         base_x,
    output logic [COORD_BITS-1:0]         base_y
);
    import sic_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int D1 = C + 1;
    localparam int PW = 2 * C + 2;
    localparam int XW = 2 * C + 3;
    localparam int DW = 2 * C + 2;

    // stage 1: differences and collinear span class
    logic signed [D1-1:0] xba_next, yba_next, xdc_next, ydc_next, xca_next, yca_next;
    logic signed [D1-1:0] xba1_reg, yba1_reg, xdc_reg, ydc_reg, xca_reg, yca_reg;
    logic signed [C-1:0]  sp, sq, sr, ss, a_lo, b_hi, c_lo, d_hi;
    status_t              col_next, col1_reg, col2_reg, col3_reg, col4_reg;
    logic [C-1:0]         ax1_reg, ay1_reg, ax2_reg, ay2_reg, ax3_reg, ay3_reg;
    logic [C-1:0]         ax4_reg, ay4_reg;

    always_comb
    begin
        xba_next = D1'(bx) - D1'(ax);
        yba_next = D1'(by) - D1'(ay);
        xdc_next = D1'(dx) - D1'(cx);
        ydc_next = D1'(dy) - D1'(cy);
        xca_next = D1'(cx) - D1'(ax);
        yca_next = D1'(cy) - D1'(ay);
        sp = (ax != bx) ? ax : ay;
        sq = (ax != bx) ? bx : by;
        sr = (ax != bx) ? cx : cy;
        ss = (ax != bx) ? dx : dy;
        a_lo = (sp < sq) ? sp : sq;
        b_hi = (sp < sq) ? sq : sp;
        c_lo = (sr < ss) ? sr : ss;
        d_hi = (sr < ss) ? ss : sr;
        if (d_hi < a_lo || c_lo > b_hi)
            col_next = ST_DISJOINT;
        else if (d_hi == a_lo || c_lo == b_hi)
            col_next = ST_TOUCH;
        else
            col_next = ST_OVERLAP;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xba1_reg <= xba_next;
            yba1_reg <= yba_next;
            xdc_reg  <= xdc_next;
            ydc_reg  <= ydc_next;
            xca_reg  <= xca_next;
            yca_reg  <= yca_next;
            col1_reg <= col_next;
            ax1_reg  <= ax;
            ay1_reg  <= ay;
        end
    end

    // stage 2: six products
    logic signed [PW-1:0] m_reg [6];
    logic signed [D1-1:0] xba2_reg, yba2_reg, xba3_reg, yba3_reg, xba4_reg, yba4_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            m_reg[0] <= PW'(xba1_reg) * PW'(ydc_reg);
            m_reg[1] <= PW'(yba1_reg) * PW'(xdc_reg);
            m_reg[2] <= PW'(xca_reg) * PW'(ydc_reg);
            m_reg[3] <= PW'(yca_reg) * PW'(xdc_reg);
            m_reg[4] <= PW'(xca_reg) * PW'(yba1_reg);
            m_reg[5] <= PW'(yca_reg) * PW'(xba1_reg);
            xba2_reg <= xba1_reg;
            yba2_reg <= yba1_reg;
            col2_reg <= col1_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
        end
    end

    // stage 3: cross products
    logic signed [XW-1:0] delta_reg, t1c_reg, t2c_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            delta_reg <= XW'(m_reg[0]) - XW'(m_reg[1]);
            t1c_reg   <= XW'(m_reg[2]) - XW'(m_reg[3]);
            t2c_reg   <= XW'(m_reg[4]) - XW'(m_reg[5]);
            xba3_reg  <= xba2_reg;
            yba3_reg  <= yba2_reg;
            col3_reg  <= col2_reg;
            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
        end
    end

    // stage 4: fold delta sign into t1, t2
    logic signed [XW-1:0] t1n_reg, t2n_reg;
    logic [DW-1:0]        dmag_reg;
    logic                 dz_reg, t1z_reg, t2z_reg;
    logic                 dneg;
    logic signed [XW-1:0] dabs;

    always_comb
    begin
        dneg = delta_reg[XW-1];
        dabs = dneg ? -delta_reg : delta_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            t1n_reg  <= dneg ? -t1c_reg : t1c_reg;
            t2n_reg  <= dneg ? -t2c_reg : t2c_reg;
            dmag_reg <= dabs[DW-1:0];
            dz_reg   <= (delta_reg == '0);
            t1z_reg  <= (t1c_reg == '0);
            t2z_reg  <= (t2c_reg == '0);
            xba4_reg <= xba3_reg;
            yba4_reg <= yba3_reg;
            col4_reg <= col3_reg;
            ax4_reg  <= ax3_reg;
            ay4_reg  <= ay3_reg;
        end
    end

    // stage 5: range tests and class
    logic    in_range;
    status_t st_next;

    always_comb
    begin
        in_range = !t1n_reg[XW-1] && !t2n_reg[XW-1]
                && ($unsigned(t1n_reg) <= {1'b0, dmag_reg})
                && ($unsigned(t2n_reg) <= {1'b0, dmag_reg});
        if (!dz_reg)
            st_next = in_range ? ST_HIT : ST_NONE;
        else if (!t1z_reg && !t2z_reg)
            st_next = ST_PARALLEL;
        else
            st_next = col4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            status <= st_next;
            hit    <= !dz_reg && in_range;
            t1     <= t1n_reg[DW-1:0];
            den    <= dmag_reg;
            sx     <= xba4_reg[D1-1] ? D1'(-xba4_reg) : D1'(xba4_reg);
            sy     <= yba4_reg[D1-1] ? D1'(-yba4_reg) : D1'(yba4_reg);
            negx   <= xba4_reg[D1-1];
            negy   <= yba4_reg[D1-1];
            base_x <= ax4_reg;
            base_y <= ay4_reg;
        end
    end

endmodule

// ===== sv/sic_divide.sv =====
// Pipelined shift-add-divide: floor(t1*m/den) and remainder, one
// multiplier bit per stage, three lanes (u, x, y). No dependencies.
`timescale 1ns / 1ps

module sic_divide #(
    parameter int DW = 50,
    parameter int K  = 25,
    parameter int MW = 25,
    parameter int FRAC_BITS = 16,
    parameter int SW = 54
) (
    input  logic           clk,
    input  logic [K-1:0]   en,
    input  logic [DW-1:0]  t1,
    input  logic [DW-1:0]  den,
    input  logic [MW-1:0]  mx,
    input  logic [MW-1:0]  my,
    input  logic [SW-1:0]  side_in,
    output logic [K-1:0]   qu,
    output logic [K-1:0]   qx,
    output logic [K-1:0]   qy,
    output logic [DW-1:0]  rx,
    output logic [DW-1:0]  ry,
    output logic [DW-1:0]  den_out,
    output logic [SW-1:0]  side_out
);
    localparam int RW = DW + 2;
    localparam logic [K-1:0] MU = {{(K-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic [DW-1:0] t1_reg   [K];
    logic [DW-1:0] den_reg  [K];
    logic [SW-1:0] side_reg [K];
    logic [K-1:0]  m_reg    [K][3];
    logic [DW-1:0] r_reg    [K][3];
    logic [K-1:0]  q_reg    [K][3];

    for (genvar j = 0; j < K; j++)
    begin : g_stage
        logic [DW-1:0] t1_in, den_in;
        logic [SW-1:0] side_in_j;

        if (j == 0)
        begin : g_first
            assign t1_in     = t1;
            assign den_in    = den;
            assign side_in_j = side_in;
        end
        else
        begin : g_rest
            assign t1_in     = t1_reg[j-1];
            assign den_in    = den_reg[j-1];
            assign side_in_j = side_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                t1_reg[j]   <= t1_in;
                den_reg[j]  <= den_in;
                side_reg[j] <= side_in_j;
            end
        end

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [K-1:0]  m_in, q_in, q_next;
            logic [DW-1:0] r_in, r_next;
            logic [RW-1:0] rr, one_d, two_d;
            logic          ge1, ge2;

            if (j == 0)
            begin : g_first
                assign m_in = (l == 0) ? MU : ((l == 1) ? K'(mx) : K'(my));
                assign r_in = '0;
                assign q_in = '0;
            end
            else
            begin : g_rest
                assign m_in = m_reg[j-1][l];
                assign r_in = r_reg[j-1][l];
                assign q_in = q_reg[j-1][l];
            end

            always_comb
            begin
                one_d  = RW'(den_in);
                two_d  = {1'b0, den_in, 1'b0};
                rr     = {r_in, 1'b0} + (m_in[K-1-j] ? RW'(t1_in) : '0);
                ge2    = (rr >= two_d);
                ge1    = (rr >= one_d);
                r_next = DW'(rr - (ge2 ? two_d : (ge1 ? one_d : '0)));
                q_next = {q_in[K-2:0], 1'b0} + {{(K-2){1'b0}}, ge2, ge1 && !ge2};
            end

            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    m_reg[j][l] <= m_in;
                    r_reg[j][l] <= r_next;
                    q_reg[j][l] <= q_next;
                end
            end
        end
    end

    assign qu       = q_reg[K-1][0];
    assign qx       = q_reg[K-1][1];
    assign qy       = q_reg[K-1][2];
    assign rx       = r_reg[K-1][1];
    assign ry       = r_reg[K-1][2];
    assign den_out  = den_reg[K-1];
    assign side_out = side_reg[K-1];

endmodule

// ===== sv/sic_back.sv =====
// Output stage: round-to-nearest offsets, point, Q1.F parameter.
// Depends on sic_pkg.
`timescale 1ns / 1ps

module sic_back #(
    parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sic_pkg::FRAC_BITS_DEF,
    parameter int K          = 25
) (
    input  logic                         clk,
    input  logic                         en,
    input  sic_pkg::status_t             status_in,
    input  logic                         hit,
    input  logic                         negx,
    input  logic                         negy,
    input  logic [COORD_BITS-1:0]        base_x,
    input  logic [COORD_BITS-1:0]        base_y,
    input  logic [K-1:0]                 qu,
    input  logic [K-1:0]                 qx,
    input  logic [K-1:0]                 qy,
    input  logic [2*COORD_BITS+1:0]      rx,
    input  logic [2*COORD_BITS+1:0]      ry,
    input  logic [2*COORD_BITS+1:0]      den,
    output logic [sic_pkg::STATUS_W-1:0] status,
    output logic [COORD_BITS-1:0]        hit_x,
    output logic [COORD_BITS-1:0]        hit_y,
    output logic [FRAC_BITS:0]           u_fraction
);
    import sic_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int DW = 2 * C + 2;

    logic [DW:0]  twice_rx, twice_ry;
    logic         rnd_x, rnd_y;
    logic [C-1:0] mag_x, mag_y, off_x, off_y;

    // ties go toward +inf: a negative span rounds up only past the half
    always_comb
    begin
        twice_rx = {rx, 1'b0};
        twice_ry = {ry, 1'b0};
        rnd_x = negx ? (twice_rx > {1'b0, den}) : (twice_rx >= {1'b0, den});
        rnd_y = negy ? (twice_ry > {1'b0, den}) : (twice_ry >= {1'b0, den});
        mag_x = C'(qx) + C'(rnd_x);
        mag_y = C'(qy) + C'(rnd_y);
        off_x = negx ? -mag_x : mag_x;
        off_y = negy ? -mag_y : mag_y;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status     <= status_in;
            hit_x      <= hit ? base_x + off_x : '0;
            hit_y      <= hit ? base_y + off_y : '0;
            u_fraction <= hit ? qu[FRAC_BITS:0] : '0;
        end
    end

endmodule

// ===== sv/segment_intersection_classify.sv =====
// Top level of the segment intersection classifier.
// Depends on sic_pkg, sic_stream_if, sic_front, sic_divide, sic_back.
`timescale 1ns / 1ps

// Takes one segment pair per cycle unless backpressure stalls it and returns one
// result per pair, in order. The pipeline is five front stages (differences,
// products, cross products, sign fold, range tests), one divider stage per
// multiplier bit for the exact parameter and rounded point, and the output
// register. Every stage holds its item under backpressure and empty stages fill
// while the output waits, so the input stays open until the whole pipeline
// is full.
module segment_intersection_classify #(
    parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sic_pkg::FRAC_BITS_DEF
) (
    input logic      clk,
    input logic      rst_n,
    sic_seg_if.sink  segs,
    sic_res_if.source result
);
    import sic_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int DW = 2 * C + 2;
    localparam int K  = (C > FRAC_BITS) ? C + 1 : FRAC_BITS + 1;
    localparam int NS = K + 6;
    localparam int SW = 2 * C + 6;

    logic [NS-1:0] v_reg, v_next, en;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || result.ready;
        for (int i = NS - 2; i >= 0; i--)
            en[i] = !v_reg[i] || en[i+1];
        v_next = {v_reg[NS-2:0], segs.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int i = 0; i < NS; i++)
                if (en[i])
                    v_reg[i] <= v_next[i];
        end
    end

    assign segs.ready   = en[0];
    assign result.valid = v_reg[NS-1];

    status_t       f_status;
    logic          f_hit, f_negx, f_negy;
    logic [DW-1:0] f_t1, f_den;
    logic [C:0]    f_sx, f_sy;
    logic [C-1:0]  f_bx, f_by;

    sic_front #(.COORD_BITS(C)) u_front (
        .clk    (clk),
        .en     (en[4:0]),
        .ax     (segs.ax),
        .ay     (segs.ay),
        .bx     (segs.bx),
        .by     (segs.by),
        .cx     (segs.cx),
        .cy     (segs.cy),
        .dx     (segs.dx),
        .dy     (segs.dy),
        .status (f_status),
        .hit    (f_hit),
        .t1     (f_t1),
        .den    (f_den),
        .sx     (f_sx),
        .sy     (f_sy),
        .negx   (f_negx),
        .negy   (f_negy),
        .base_x (f_bx),
        .base_y (f_by)
    );

    logic [SW-1:0] side_in, side_out;
    logic [K-1:0]  qu, qx, qy;
    logic [DW-1:0] rx, ry, d_den;

    assign side_in = {f_status, f_hit, f_negx, f_negy, f_bx, f_by};

    sic_divide #(
        .DW        (DW),
        .K         (K),
        .MW        (C + 1),
        .FRAC_BITS (FRAC_BITS),
        .SW        (SW)
    ) u_divide (
        .clk      (clk),
        .en       (en[K+4:5]),
        .t1       (f_t1),
        .den      (f_den),
        .mx       (f_sx),
        .my       (f_sy),
        .side_in  (side_in),
        .qu       (qu),
        .qx       (qx),
        .qy       (qy),
        .rx       (rx),
        .ry       (ry),
        .den_out  (d_den),
        .side_out (side_out)
    );

    status_t d_status;
    logic    d_hit, d_negx, d_negy;

    assign d_status = status_t'(side_out[SW-1 -: STATUS_W]);
    assign d_hit    = side_out[2*C+2];
    assign d_negx   = side_out[2*C+1];
    assign d_negy   = side_out[2*C];

    sic_back #(
        .COORD_BITS (C),
        .FRAC_BITS  (FRAC_BITS),
        .K          (K)
    ) u_back (
        .clk        (clk),
        .en         (en[NS-1]),
        .status_in  (d_status),
        .hit        (d_hit),
        .negx       (d_negx),
        .negy       (d_negy),
        .base_x     (side_out[2*C-1:C]),
        .base_y     (side_out[C-1:0]),
        .qu         (qu),
        .qx         (qx),
        .qy         (qy),
        .rx         (rx),
        .ry         (ry),
        .den        (d_den),
        .status     (result.status),
        .hit_x      (result.hit_x),
        .hit_y      (result.hit_y),
        .u_fraction (result.u_fraction)
    );

endmodule

// ===== sv/sic_checker.sv =====
// Port-level checks for segment_intersection_classify, bound to the top.
// Depends on sic_pkg and segment_intersection_classify_assert.svh.
`timescale 1ns / 1ps
`include "segment_intersection_classify_assert.svh"

module sic_checker #(
    parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sic_pkg::FRAC_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         valid,
    input logic                         ready,
    input logic [sic_pkg::STATUS_W-1:0] status,
    input logic [COORD_BITS-1:0]        hit_x,
    input logic [COORD_BITS-1:0]        hit_y,
    input logic [FRAC_BITS:0]           u_fraction
);
    import sic_pkg::*;

    localparam logic [FRAC_BITS:0] U_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // no hit: point and parameter are zero
    `SIC_ASSERT_IMPLIES(a_miss_zero, valid && status != ST_HIT, hit_x == '0 && hit_y == '0 && u_fraction == '0)
    // parameter never above one
    `SIC_ASSERT_IMPLIES(a_u_range, valid, u_fraction <= U_ONE)
    // nothing comes out right after reset
    `SIC_ASSERT_IMPLIES(a_reset_empty, !$past(rst_n), !valid)
    // stalled item holds
    `SIC_ASSERT_NEXT(a_hold, valid && !ready, valid && $stable(status) && $stable(hit_x) && $stable(hit_y) && $stable(u_fraction))

endmodule

bind segment_intersection_classify sic_checker #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
) u_sic_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (result.valid),
    .ready      (result.ready),
    .status     (result.status),
    .hit_x      (result.hit_x),
    .hit_y      (result.hit_y),
    .u_fraction (result.u_fraction)
);

// ===== verif/tb.sv =====
// Self-checking testbench for segment_intersection_classify: directed and random segment pairs,
// with random idling on both channels and a long output hold-off; results checked in order.
// Depends on sic_pkg, sic_seg_if, sic_res_if and the block RTL.
`timescale 1ns / 1ps

module tb;
    import sic_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES = 300;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [127:0] wide_t;

    typedef struct {
        coord_t ax, ay, bx, by, cx, cy, dx, dy;
    } seg_pair_t;

    typedef struct {
        status_t     status;
        coord_t      hit_x;
        coord_t      hit_y;
        logic [FB:0] u_fraction;
    } isect_t;

    class isect_scoreboard;
        isect_t pending[$];
        int     errors;
        int     checked;
        int     seen[6];

        static function status_t span_class(coord_t p, coord_t q, coord_t r, coord_t s);
            coord_t a, b, c, d;
            a = (p < q) ? p : q;
            b = (p < q) ? q : p;
            c = (r < s) ? r : s;
            d = (r < s) ? s : r;
            if (d < a || c > b)
                return ST_DISJOINT;
            if (d == a || c == b)
                return ST_TOUCH;
            return ST_OVERLAP;
        endfunction

        static function coord_t round_point(coord_t base, wide_t t1, wide_t span, wide_t den);
            wide_t n, d2, q;
            n  = 2 * t1 * span + den;
            d2 = 2 * den;
            q  = n / d2;
            if (n < 0 && q * d2 != n)
                q = q - 1;
            return coord_t'(base + q[CB-1:0]);
        endfunction

        static function isect_t classify(seg_pair_t p);
            wide_t xba, yba, xdc, ydc, xca, yca, dl, t1, t2, num;
            isect_t e;
            xba = wide_t'(p.bx) - wide_t'(p.ax);
            yba = wide_t'(p.by) - wide_t'(p.ay);
            xdc = wide_t'(p.dx) - wide_t'(p.cx);
            ydc = wide_t'(p.dy) - wide_t'(p.cy);
            xca = wide_t'(p.cx) - wide_t'(p.ax);
            yca = wide_t'(p.cy) - wide_t'(p.ay);
            dl = xba * ydc - yba * xdc;
            t1 = xca * ydc - yca * xdc;
            t2 = xca * yba - yca * xba;
            e.status = ST_NONE;
            e.hit_x = '0;
            e.hit_y = '0;
            e.u_fraction = '0;
            if (dl != 0) begin
                if (dl < 0) begin
                    dl = -dl;
                    t1 = -t1;
                    t2 = -t2;
                end
                if (t1 >= 0 && t2 >= 0 && t1 <= dl && t2 <= dl) begin
                    e.status = ST_HIT;
                    num = (t1 <<< FB) / dl;
                    e.u_fraction = num[FB:0];
                    e.hit_x = round_point(p.ax, t1, xba, dl);
                    e.hit_y = round_point(p.ay, t1, yba, dl);
                end
            end else if (t1 != 0 && t2 != 0)
                e.status = ST_PARALLEL;
            else if (p.ax != p.bx)
                e.status = span_class(p.ax, p.bx, p.cx, p.dx);
            else
                e.status = span_class(p.ay, p.by, p.cy, p.dy);
            return e;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch on result %0d: %s got %0d expected %0d", checked, what, got, want);
            errors++;
        endtask

        function void note_pair(seg_pair_t p);
            pending.push_back(classify(p));
        endfunction

        task check_result(logic [2:0] st, coord_t hx, coord_t hy, logic [FB:0] uf);
            isect_t e;
            if (pending.size() == 0) begin
                report("unexpected item, status", st, 0);
                return;
            end
            e = pending.pop_front();
            if (st != e.status)
                report("status", st, e.status);
            if (hx != e.hit_x)
                report("hit_x", hx, e.hit_x);
            if (hy != e.hit_y)
                report("hit_y", hy, e.hit_y);
            if (uf != e.u_fraction)
                report("u_fraction", uf, e.u_fraction);
            if (e.status <= ST_OVERLAP)
                seen[e.status]++;
            checked++;
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycles = 0;
    int   sent = 0;
    bit   quiet = 1'b0;
    bit   hold_done = 1'b0;

    sic_seg_if segs_if ();
    sic_res_if res_if ();
    isect_scoreboard sb = new();

    segment_intersection_classify DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .segs  (segs_if),
        .result(res_if)
    );

    always #2 clk = ~clk;

    initial
    begin
        segs_if.valid = 1'b0;
        {segs_if.ax, segs_if.ay, segs_if.bx, segs_if.by} = '0;
        {segs_if.cx, segs_if.cy, segs_if.dx, segs_if.dy} = '0;
        res_if.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.status, res_if.hit_x, res_if.hit_y, res_if.u_fraction);

    // receiver: random stalls, one long hold-off while the sender keeps offering
    initial
    begin
        int held;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!hold_done && sent >= 300) begin
                res_if.ready = 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            res_if.ready = quiet ? 1'b1 : ($urandom_range(0, 99) >= 8);
        end
    end

    task automatic send_pair(seg_pair_t p);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 8) begin
            segs_if.valid = 1'b0;
            @(negedge clk);
        end
        segs_if.ax = p.ax;
        segs_if.ay = p.ay;
        segs_if.bx = p.bx;
        segs_if.by = p.by;
        segs_if.cx = p.cx;
        segs_if.cy = p.cy;
        segs_if.dx = p.dx;
        segs_if.dy = p.dy;
        segs_if.valid = 1'b1;
        do
            @(posedge clk);
        while (!segs_if.ready);
        sb.note_pair(p);
        sent++;
    endtask

    function automatic seg_pair_t mk(int a0, int a1, int b0, int b1,
                                     int c0, int c1, int d0, int d1);
        seg_pair_t p;
        p.ax = coord_t'(a0);
        p.ay = coord_t'(a1);
        p.bx = coord_t'(b0);
        p.by = coord_t'(b1);
        p.cx = coord_t'(c0);
        p.cy = coord_t'(c1);
        p.dx = coord_t'(d0);
        p.dy = coord_t'(d1);
        return p;
    endfunction

    function automatic coord_t pick_edge();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(CB-1){1'b0}}};
            1: return {1'b0, {(CB-1){1'b1}}};
            2: return '0;
            3: return '1;
            4: return coord_t'(1);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int px, py, vx, vy, wx, wy, ka, kb, kc, kd, r;
        px = $urandom_range(0, 2000000) - 1000000;
        py = $urandom_range(0, 2000000) - 1000000;
        vx = $urandom_range(0, 200) - 100;
        vy = $urandom_range(0, 200) - 100;
        wx = $urandom_range(0, 20) - 10;
        wy = $urandom_range(0, 20) - 10;
        ka = $urandom_range(0, 10) - 5;
        kb = $urandom_range(0, 10) - 5;
        kc = $urandom_range(0, 10) - 5;
        kd = $urandom_range(0, 10) - 5;
        r = $urandom_range(0, 99);
        if (r < 25)
            p = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (r < 40)
            p = mk($urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
                   $urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
                   $urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
                   $urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8);
        else if (r < 60)
            p = mk(px + $urandom_range(0, 2000) - 1000, py + $urandom_range(0, 2000) - 1000,
                   px + $urandom_range(0, 2000) - 1000, py + $urandom_range(0, 2000) - 1000,
                   px + $urandom_range(0, 2000) - 1000, py + $urandom_range(0, 2000) - 1000,
                   px + $urandom_range(0, 2000) - 1000, py + $urandom_range(0, 2000) - 1000);
        else if (r < 78) begin
            if ($urandom_range(0, 3) == 0)
                vx = 0;
            p = mk(px + ka * vx, py + ka * vy, px + kb * vx, py + kb * vy,
                   px + kc * vx, py + kc * vy, px + kd * vx, py + kd * vy);
        end else if (r < 88)
            p = mk(px + ka * vx, py + ka * vy, px + kb * vx, py + kb * vy,
                   px + kc * vx + wx, py + kc * vy + wy, px + kd * vx + wx, py + kd * vy + wy);
        else begin
            p.ax = pick_edge();
            p.ay = pick_edge();
            p.bx = pick_edge();
            p.by = pick_edge();
            p.cx = pick_edge();
            p.cy = pick_edge();
            p.dx = pick_edge();
            p.dy = pick_edge();
        end
        return p;
    endfunction

    initial
    begin
        seg_pair_t dir[$];
        int i;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        dir.push_back(mk(0, 0, 10, 10, 0, 10, 10, 0));
        dir.push_back(mk(0, 0, 3, 1, 0, 1, 3, 0));
        dir.push_back(mk(0, 0, 10, 0, 10, 0, 10, 10));
        dir.push_back(mk(0, 0, 10, 0, 0, 0, 0, 10));
        dir.push_back(mk(0, 0, 10, 0, 11, -5, 11, 5));
        dir.push_back(mk(0, 0, 10, 0, 0, 1, 10, 1));
        dir.push_back(mk(0, 0, 10, 0, 11, 0, 20, 0));
        dir.push_back(mk(0, 0, 10, 0, 10, 0, 20, 0));
        dir.push_back(mk(0, 0, 10, 0, 5, 0, 20, 0));
        dir.push_back(mk(3, 0, 3, 10, 3, 12, 3, 15));
        dir.push_back(mk(3, 0, 3, 10, 3, -4, 3, 0));
        dir.push_back(mk(3, 0, 3, 10, 3, 15, 3, 5));
        dir.push_back(mk(5, 5, 5, 5, 5, 5, 5, 5));
        dir.push_back(mk(5, 5, 5, 5, 0, 0, 9, 9));
        dir.push_back(mk(5, 5, 5, 5, 6, 6, 9, 9));
        dir.push_back(mk(-8388608, -8388608, 8388607, 8388607, -8388608, 8388607, 8388607, -8388608));
        dir.push_back(mk(8388607, -8388608, -8388608, 8388607, 8388607, 8388607, -8388608, -8388608));
        dir.push_back(mk(-8388608, 0, 8388607, 0, 0, -8388608, 1, 8388607));
        dir.push_back(mk(-8388608, -8388608, 8388607, 8388607, -8388608, -8388608, 8388607, 8388607));
        dir.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1));
        dir.push_back(mk(0, 0, 1, 2, 1, 0, 0, 1));
        dir.push_back(mk(0, 0, 2, 1, 1, 0, 1, 1));
        foreach (dir[k])
            send_pair(dir[k]);

        for (i = 0; i < 900; i++) begin
            quiet = (i >= 450 && i < 600);
            send_pair(random_pair());
        end
        quiet = 1'b0;
        @(negedge clk);
        segs_if.valid = 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d pairs sent, %0d results checked over %0d cycles", sent, sb.checked, cycles);
        $display("by class: none %0d, hit %0d, parallel %0d, disjoint %0d, touch %0d, overlap %0d",
                 sb.seen[0], sb.seen[1], sb.seen[2], sb.seen[3], sb.seen[4], sb.seen[5]);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
